// File: sv/euler_to_quaternion_macros.svh
// Assertion macros for the euler_to_quaternion block.
// Used by the top level and the CORDIC pipeline.
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// Assert that a condition implies another in the same cycle.
`define E2Q_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Assert that a condition implies another in the next cycle.
`define E2Q_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: sv/e2q_pkg.sv
// Package for euler_to_quaternion: payload types, CORDIC constants.
// No dependencies.
`timescale 1ns / 1ps
package e2q_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int COMPONENT_BITS = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int FRAC_BITS = 30;
    localparam int CW = 32;                 // Q2.30 datapath width
    localparam int ZW = 35;                 // phase width
    localparam int PW = 64;                 // product width
    localparam logic signed [CW-1:0] CORDIC_INIT_X = 32'sd652032874;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
    } e2q_in_t;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] quat_x;
        logic signed [COMPONENT_BITS-1:0] quat_y;
        logic signed [COMPONENT_BITS-1:0] quat_z;
        logic signed [COMPONENT_BITS-1:0] quat_w;
    } e2q_out_t;

    typedef struct packed {
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] c;
    } sincos_t;

    // Doubled arctangent table, phase units of 2^32 per turn.
    function automatic logic signed [ZW-1:0] atan2x(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
                3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
                6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
                9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
                15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
                18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
                21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
                24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
                27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
                default: t = 32'h0;
            endcase
            atan2x = signed'({2'b00, t, 1'b0});
        end
    endfunction

    // Q2.30 product floored back to Q2.30.
    function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [PW-1:0] p;
        begin
            p = PW'(a) * PW'(b);
            qmul = p[FRAC_BITS +: CW];
        end
    endfunction

    // Round half up to Q1.15 and saturate.
    function automatic logic signed [COMPONENT_BITS-1:0] to_comp(
        input logic signed [CW:0] v);
        localparam int S = 31 - COMPONENT_BITS;
        logic signed [CW+1:0] r;
        begin
            r = ((CW+2)'(v) + (CW+2)'(1 << (S - 1))) >>> S;
            if (r > (CW+2)'((1 << (COMPONENT_BITS - 1)) - 1))
                to_comp = {1'b0, {(COMPONENT_BITS-1){1'b1}}};
            else if (r < -(CW+2)'(1 << (COMPONENT_BITS - 1)))
                to_comp = {1'b1, {(COMPONENT_BITS-1){1'b0}}};
            else
                to_comp = r[COMPONENT_BITS-1:0];
        end
    endfunction
endpackage

// File: sv/euler_to_quaternion.sv
// Top level of the Euler-angle to quaternion converter.
// Depends on e2q_pkg and e2q_cordic (three instances).
//
// Channel   Handshake          Payload
// input     start / busy       in  (e2q_in_t: roll, pitch, yaw)
// result    done (strobe)      out (e2q_out_t: x, y, z, w)
//
// Pipeline: 30 CORDIC stages + 4 product, sum and rounding stages.
// Throughput: one transfer per cycle; the 30 unrolled CORDIC steps set depth.
// busy is tied low: the pipeline never stalls since the receiver cannot.
// Reset clears only valid bits; data registers hold arbitrary values.
`timescale 1ns / 1ps
`include "euler_to_quaternion_macros.svh"
module euler_to_quaternion
    import e2q_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  e2q_in_t  in,
    output logic     done,
    output e2q_out_t out
);
    logic    accept;
    logic    vr, vp, vy;
    sincos_t r, p, y;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    e2q_cordic u_roll  (.clk, .rst_n, .in_valid(accept), .angle(in.roll_angle),
                        .out_valid(vr), .result(r));
    e2q_cordic u_pitch (.clk, .rst_n, .in_valid(accept), .angle(in.pitch_angle),
                        .out_valid(vp), .result(p));
    e2q_cordic u_yaw   (.clk, .rst_n, .in_valid(accept), .angle(in.yaw_angle),
                        .out_valid(vy), .result(y));

    // Stage A: pair products (one multiply each) and registered yaw sine/cosine.
    logic                 a_v_reg;
    logic signed [CW-1:0] srcp_reg, crsp_reg, crcp_reg, srsp_reg, cy_reg, sy_reg;
    // Stage B: triple products.
    logic                 b_v_reg;
    logic signed [CW-1:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    // Stage C: sums.
    logic                 c_v_reg;
    logic signed [CW:0]   sx_reg, sy2_reg, sz_reg, sw_reg;
    // Stage D: rounded output.
    logic                 done_reg;
    e2q_out_t             out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            c_v_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            a_v_reg  <= vr;
            b_v_reg  <= a_v_reg;
            c_v_reg  <= b_v_reg;
            done_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        srcp_reg <= qmul(r.s, p.c);
        crsp_reg <= qmul(r.c, p.s);
        crcp_reg <= qmul(r.c, p.c);
        srsp_reg <= qmul(r.s, p.s);
        cy_reg   <= y.c;
        sy_reg   <= y.s;

        t0_reg <= qmul(srcp_reg, cy_reg);
        t1_reg <= qmul(crsp_reg, sy_reg);
        t2_reg <= qmul(crsp_reg, cy_reg);
        t3_reg <= qmul(srcp_reg, sy_reg);
        t4_reg <= qmul(crcp_reg, sy_reg);
        t5_reg <= qmul(srsp_reg, cy_reg);
        t6_reg <= qmul(crcp_reg, cy_reg);
        t7_reg <= qmul(srsp_reg, sy_reg);

        sx_reg  <= (CW+1)'(t0_reg) - (CW+1)'(t1_reg);
        sy2_reg <= (CW+1)'(t2_reg) + (CW+1)'(t3_reg);
        sz_reg  <= (CW+1)'(t4_reg) - (CW+1)'(t5_reg);
        sw_reg  <= (CW+1)'(t6_reg) + (CW+1)'(t7_reg);

        out_reg.quat_x <= to_comp(sx_reg);
        out_reg.quat_y <= to_comp(sy2_reg);
        out_reg.quat_z <= to_comp(sz_reg);
        out_reg.quat_w <= to_comp(sw_reg);
    end

    assign done = done_reg;
    assign out  = out_reg;

    `E2Q_ASSERT_IMPL(a_lanes_aligned, clk, rst_n, vr, vp && vy, "CORDIC lanes out of step")
    `E2Q_ASSERT_NEXT(a_a_to_b, clk, rst_n, a_v_reg, b_v_reg, "valid lost after products")
    `E2Q_ASSERT_NEXT(a_c_to_done, clk, rst_n, c_v_reg, done, "valid lost before output")
    `E2Q_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")
endmodule

// File: sv/e2q_cordic.sv
// Unrolled, pipelined rotation-mode CORDIC: half-angle sine and cosine.
// Depends on e2q_pkg; one register stage per CORDIC step.
`timescale 1ns / 1ps
`include "euler_to_quaternion_macros.svh"
module e2q_cordic
    import e2q_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output logic                         out_valid,
    output sincos_t                      result
);
    logic                 v_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];

    always_comb
    begin
        v_reg[0] = in_valid;
        x_reg[0] = CORDIC_INIT_X;
        y_reg[0] = '0;
        z_reg[0] = ZW'(angle) <<< (32 - ANGLE_BITS);
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;
        always_comb
        begin
            if (!z_reg[i][ZW-1]) begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - atan2x(i);
            end else begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + atan2x(i);
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg[i+1] <= 1'b0;
            else        v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            x_reg[i+1] <= x_next;
            y_reg[i+1] <= y_next;
            z_reg[i+1] <= z_next;
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS];
    assign result.s  = y_reg[CORDIC_STEPS];
    assign result.c  = x_reg[CORDIC_STEPS];

    `E2Q_ASSERT_NEXT(a_valid_moves, clk, rst_n, v_reg[0], v_reg[1], "valid lost in stage 0")
    `E2Q_ASSERT_NEXT(a_valid_out, clk, rst_n, v_reg[CORDIC_STEPS-1], out_valid, "valid lost at end")
    `E2Q_ASSERT_NEXT(a_idle_moves, clk, rst_n, !v_reg[0], !v_reg[1], "valid invented")
endmodule
